/* rtl/cesd_pkg.sv */
// Shared types and constants of the calibrated edge stop detector.
package cesd_pkg;

   // Sample width used when the top level is not given one.
   localparam int SAMPLE_BITS_DEF = 12;

   // Reset values of the configuration registers.
   localparam int MIN_SPAN_RST   = 300;
   localparam int FALLBACK_RST   = 3700;
   localparam int CONFIRM_RST    = 4;
   localparam int SPEED_RST      = 55;

   // Fixed field widths.
   localparam int TYPE_BITS      = 2;
   localparam int HIT_BITS       = 4;
   localparam int SPEED_BITS     = 7;
   localparam int DUTY_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;

   // Duty scaling: duty = speed * 255 / 100, speed saturated at 100.
   localparam int SPEED_MAX      = 100;
   localparam int DUTY_FULL      = 255;
   localparam int SPEED_PROD_BITS = 15;
   // floor(x / 100) == (x * 5243) >> 19 for every x up to 100 * 255.
   localparam int DUTY_RECIP      = 5243;
   localparam int DUTY_SHIFT      = 19;
   localparam int DUTY_PROD_BITS  = 28;

   // Request kinds. Code three is unused and leaves all state alone.
   typedef enum logic [TYPE_BITS-1:0] {
      REQ_CAL_SAMPLE = 2'd0,
      REQ_CAL_END    = 2'd1,
      REQ_RUN        = 2'd2
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_SPAN = 3'd0,
      CSR_FALLBACK = 3'd1,
      CSR_CONFIRM  = 3'd2,
      CSR_SPEED    = 3'd3
   } csr_index_type;

   // Calibration strobes from the top level to the calibration unit.
   typedef struct packed {
      logic cal_sample;
      logic cal_end;
   } calib_ctl_type;

endpackage

/* rtl/cesd_calib.sv */
// Calibration unit: min/max trackers and per-sensor thresholds.
module cesd_calib #(
   parameter int SAMPLE_BITS = cesd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cesd_pkg::calib_ctl_type ctl,
   input  logic [SAMPLE_BITS-1:0] left_sample,
   input  logic [SAMPLE_BITS-1:0] right_sample,
   input  logic [SAMPLE_BITS-1:0] min_span,
   input  logic [SAMPLE_BITS-1:0] fallback,
   output logic [SAMPLE_BITS-1:0] left_level,
   output logic [SAMPLE_BITS-1:0] right_level,
   output logic [SAMPLE_BITS-1:0] left_level_next,
   output logic [SAMPLE_BITS-1:0] right_level_next
);

   logic [SAMPLE_BITS-1:0] left_low_ff, left_low_in;
   logic [SAMPLE_BITS-1:0] left_high_ff, left_high_in;
   logic [SAMPLE_BITS-1:0] right_low_ff, right_low_in;
   logic [SAMPLE_BITS-1:0] right_high_ff, right_high_in;
   logic [SAMPLE_BITS-1:0] left_thresh_ff, left_thresh_in;
   logic [SAMPLE_BITS-1:0] right_thresh_ff, right_thresh_in;
   logic [SAMPLE_BITS-1:0] left_settle, right_settle;

   // Midpoint when the span is wide enough, fallback otherwise.
   function automatic logic [SAMPLE_BITS-1:0] settle(
      input logic [SAMPLE_BITS-1:0] lo,
      input logic [SAMPLE_BITS-1:0] hi,
      input logic [SAMPLE_BITS-1:0] span,
      input logic [SAMPLE_BITS-1:0] fb
   );
      logic [SAMPLE_BITS:0] sum;
      logic [SAMPLE_BITS-1:0] diff;
      sum  = {1'b0, lo} + {1'b0, hi};
      diff = hi - lo;
      if (hi >= lo && diff >= span) begin
         settle = sum[SAMPLE_BITS:1];
      end else begin
         settle = fb;
      end
   endfunction

   assign left_settle  = settle(left_low_ff, left_high_ff, min_span, fallback);
   assign right_settle = settle(right_low_ff, right_high_ff, min_span, fallback);

   always_comb begin
      left_low_in     = left_low_ff;
      left_high_in    = left_high_ff;
      right_low_in    = right_low_ff;
      right_high_in   = right_high_ff;
      left_thresh_in  = left_thresh_ff;
      right_thresh_in = right_thresh_ff;
      if (ctl.cal_sample) begin
         if (left_sample < left_low_ff)   left_low_in   = left_sample;
         if (left_sample > left_high_ff)  left_high_in  = left_sample;
         if (right_sample < right_low_ff) right_low_in  = right_sample;
         if (right_sample > right_high_ff) right_high_in = right_sample;
      end else if (ctl.cal_end) begin
         // Latch the new thresholds and start the trackers over.
         left_thresh_in  = left_settle;
         right_thresh_in = right_settle;
         left_low_in     = '1;
         left_high_in    = '0;
         right_low_in    = '1;
         right_high_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_low_ff     <= '1;
         left_high_ff    <= '0;
         right_low_ff    <= '1;
         right_high_ff   <= '0;
         left_thresh_ff  <= SAMPLE_BITS'(cesd_pkg::FALLBACK_RST);
         right_thresh_ff <= SAMPLE_BITS'(cesd_pkg::FALLBACK_RST);
      end else begin
         left_low_ff     <= left_low_in;
         left_high_ff    <= left_high_in;
         right_low_ff    <= right_low_in;
         right_high_ff   <= right_high_in;
         left_thresh_ff  <= left_thresh_in;
         right_thresh_ff <= right_thresh_in;
      end
   end

   assign left_level       = left_thresh_ff;
   assign right_level      = right_thresh_ff;
   assign left_level_next  = left_thresh_in;
   assign right_level_next = right_thresh_in;

endmodule

/* rtl/calibrated_edge_stop_detector.sv */
// Top level of the calibrated edge stop detector.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_left_sample, req_right_sample
//   rsp      out        rsp_valid/rsp_stall  rsp_left_black .. rsp_right_level
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One beat per cycle sustained while rsp_stall is low. A request beat is held in
// the input register once accepted, moves into the result register when it
// advances, and can then be taken on the response side.
// State advances only at the edge that moves a beat into the result register,
// so the per-beat work is one compare set, a small counter and the midpoint.
// Reset is synchronous: it empties both stages and restores the configuration,
// calibration and stop-state registers. A stalled response holds; the input
// register keeps accepting until it is full and cannot advance, and only then is req_stall raised.
module calibrated_edge_stop_detector #(
   parameter int SAMPLE_BITS = cesd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cesd_pkg::TYPE_BITS-1:0]       req_type,
   input  logic [SAMPLE_BITS-1:0]               req_left_sample,
   input  logic [SAMPLE_BITS-1:0]               req_right_sample,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_left_black,
   output logic                                 rsp_right_black,
   output logic [cesd_pkg::HIT_BITS-1:0]        rsp_hit_count,
   output logic                                 rsp_stopped,
   output logic [cesd_pkg::DUTY_BITS-1:0]       rsp_motor_duty,
   output logic [SAMPLE_BITS-1:0]               rsp_left_level,
   output logic [SAMPLE_BITS-1:0]               rsp_right_level,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cesd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [SAMPLE_BITS-1:0]               csr_data
);

   localparam int HB = cesd_pkg::HIT_BITS;
   localparam int SB = cesd_pkg::SPEED_BITS;
   localparam int DB = cesd_pkg::DUTY_BITS;

   // ---------------- configuration registers ----------------
   logic [SAMPLE_BITS-1:0] min_span_ff;
   logic [SAMPLE_BITS-1:0] fallback_ff;
   logic [HB-1:0]          confirm_ff;
   logic [SB-1:0]          speed_ff;

   // The block never refuses a configuration beat.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_span_ff <= SAMPLE_BITS'(cesd_pkg::MIN_SPAN_RST);
         fallback_ff <= SAMPLE_BITS'(cesd_pkg::FALLBACK_RST);
         confirm_ff  <= HB'(cesd_pkg::CONFIRM_RST);
         speed_ff    <= SB'(cesd_pkg::SPEED_RST);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cesd_pkg::CSR_MIN_SPAN: min_span_ff <= csr_data;
            cesd_pkg::CSR_FALLBACK: fallback_ff <= csr_data;
            cesd_pkg::CSR_CONFIRM:  confirm_ff  <= csr_data[HB-1:0];
            cesd_pkg::CSR_SPEED:    speed_ff    <= csr_data[SB-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                            in_valid_ff;
   logic [cesd_pkg::TYPE_BITS-1:0]  in_type_ff;
   logic [SAMPLE_BITS-1:0]          in_left_ff;
   logic [SAMPLE_BITS-1:0]          in_right_ff;
   logic                            rsp_valid_ff;
   logic                            advance;

   // Move the held beat into the result register when that register is
   // empty or being drained this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff  <= req_type;
         in_left_ff  <= req_left_sample;
         in_right_ff <= req_right_sample;
      end
   end

   // ---------------- decode ----------------
   cesd_pkg::calib_ctl_type calib_ctl;
   logic                    is_run;

   always_comb begin
      calib_ctl = '0;
      is_run    = 1'b0;
      case (in_type_ff)
         cesd_pkg::REQ_CAL_SAMPLE: calib_ctl.cal_sample = advance;
         cesd_pkg::REQ_CAL_END:    calib_ctl.cal_end    = advance;
         cesd_pkg::REQ_RUN:        is_run               = 1'b1;
         default: begin
            // unused code: report state, change nothing
         end
      endcase
   end

   // ---------------- calibration ----------------
   logic [SAMPLE_BITS-1:0] left_level, right_level;
   logic [SAMPLE_BITS-1:0] left_level_next, right_level_next;

   cesd_calib #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_calib (
      .clock            (clock),
      .reset            (reset),
      .ctl              (calib_ctl),
      .left_sample      (in_left_ff),
      .right_sample     (in_right_ff),
      .min_span         (min_span_ff),
      .fallback         (fallback_ff),
      .left_level       (left_level),
      .right_level      (right_level),
      .left_level_next  (left_level_next),
      .right_level_next (right_level_next)
   );

   // ---------------- run path: compare, count, latch ----------------
   logic [HB-1:0] hit_count_ff, hit_count_in, hit_inc;
   logic          halted_ff, halted_in;
   logic          left_black, right_black;

   assign left_black  = is_run && (in_left_ff > left_level);
   assign right_black = is_run && (in_right_ff > right_level);

   // Saturate the hit count at the confirm count.
   assign hit_inc = (hit_count_ff < confirm_ff) ? hit_count_ff + HB'(1) : hit_count_ff;

   always_comb begin
      hit_count_in = hit_count_ff;
      halted_in    = halted_ff;
      if (is_run) begin
         hit_count_in = right_black ? hit_inc : '0;
         // Once confirmed, stay stopped until reset.
         halted_in    = halted_ff || (hit_count_in >= confirm_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff <= '0;
         halted_ff    <= 1'b0;
      end else if (advance) begin
         hit_count_ff <= hit_count_in;
         halted_ff    <= halted_in;
      end
   end

   // ---------------- drive duty ----------------
   logic [SB-1:0]                         speed_sat;
   logic [cesd_pkg::SPEED_PROD_BITS-1:0]  speed_prod;
   logic [cesd_pkg::DUTY_PROD_BITS-1:0]   duty_prod;
   logic [DB-1:0]                         duty_full;
   logic [DB-1:0]                         duty;

   // Clamp to one hundred percent, scale to 0..255, divide by one hundred
   // through a reciprocal multiply.
   assign speed_sat  = (speed_ff > SB'(cesd_pkg::SPEED_MAX)) ?
                       SB'(cesd_pkg::SPEED_MAX) : speed_ff;
   assign speed_prod = cesd_pkg::SPEED_PROD_BITS'(speed_sat) *
                       cesd_pkg::SPEED_PROD_BITS'(cesd_pkg::DUTY_FULL);
   assign duty_prod  = cesd_pkg::DUTY_PROD_BITS'(speed_prod) *
                       cesd_pkg::DUTY_PROD_BITS'(cesd_pkg::DUTY_RECIP);
   assign duty_full  = duty_prod[cesd_pkg::DUTY_SHIFT +: DB];
   assign duty       = (is_run && !halted_in) ? duty_full : '0;

   // ---------------- result register ----------------
   logic                   rsp_left_black_ff, rsp_right_black_ff;
   logic [HB-1:0]          rsp_hit_count_ff;
   logic                   rsp_stopped_ff;
   logic [DB-1:0]          rsp_motor_duty_ff;
   logic [SAMPLE_BITS-1:0] rsp_left_level_ff, rsp_right_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_black_ff  <= left_black;
         rsp_right_black_ff <= right_black;
         rsp_hit_count_ff   <= hit_count_in;
         rsp_stopped_ff     <= halted_in;
         rsp_motor_duty_ff  <= duty;
         rsp_left_level_ff  <= left_level_next;
         rsp_right_level_ff <= right_level_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_black  = rsp_left_black_ff;
   assign rsp_right_black = rsp_right_black_ff;
   assign rsp_hit_count   = rsp_hit_count_ff;
   assign rsp_stopped     = rsp_stopped_ff;
   assign rsp_motor_duty  = rsp_motor_duty_ff;
   assign rsp_left_level  = rsp_left_level_ff;
   assign rsp_right_level = rsp_right_level_ff;

endmodule

/* rtl/cesd_checker.sv */
// Port-level checker of the calibrated edge stop detector, bound to the top level.
module cesd_checker #(
   parameter int SAMPLE_BITS = cesd_pkg::SAMPLE_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_left_black,
   input logic                            rsp_right_black,
   input logic [cesd_pkg::HIT_BITS-1:0]   rsp_hit_count,
   input logic                            rsp_stopped,
   input logic [cesd_pkg::DUTY_BITS-1:0]  rsp_motor_duty,
   input logic [SAMPLE_BITS-1:0]          rsp_left_level,
   input logic [SAMPLE_BITS-1:0]          rsp_right_level
);

   // Set once a stopped beat has been delivered.
   logic stop_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_stopped) begin
         stop_seen_ff <= 1'b1;
      end
   end

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_black)
         && $stable(rsp_right_black) && $stable(rsp_hit_count)
         && $stable(rsp_stopped) && $stable(rsp_motor_duty)
         && $stable(rsp_left_level) && $stable(rsp_right_level))
      else $error("stalled response beat changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The stop latch never falls back before reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stop_seen_ff |-> rsp_stopped)
      else $error("stop released without reset");

   // No drive once stopped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |-> rsp_motor_duty == '0)
      else $error("motor driven while stopped");

endmodule

bind calibrated_edge_stop_detector cesd_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_cesd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_black  (rsp_left_black),
   .rsp_right_black (rsp_right_black),
   .rsp_hit_count   (rsp_hit_count),
   .rsp_stopped     (rsp_stopped),
   .rsp_motor_duty  (rsp_motor_duty),
   .rsp_left_level  (rsp_left_level),
   .rsp_right_level (rsp_right_level)
);
